// File: src/kra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_pkg
// Shared types, codes and keyword constants for the keyword risk action gate.
// ----------------------------------------------------------------------------
package kra_pkg;

  localparam int KEYWORD_SPAN = 10;
  localparam int HIST_BYTES   = KEYWORD_SPAN - 1;
  localparam int RISK_W       = 10;
  localparam int SUM_W        = RISK_W + 1;

  localparam logic [RISK_W-1:0] UNKNOWN_CLASS_RISK = 10'd100;
  localparam logic [RISK_W-1:0] THRESHOLD_RESET    = 10'd100;
  localparam logic [7:0]        CASE_OFFSET        = 8'd32;

  // keywords, first character in the top byte
  localparam logic [6*8-1:0]  KW_DELETE   = "delete";
  localparam logic [6*8-1:0]  KW_REMOVE   = "remove";
  localparam logic [4*8-1:0]  KW_KILL     = "kill";
  localparam logic [7*8-1:0]  KW_DESTROY  = "destroy";
  localparam logic [6*8-1:0]  KW_FORMAT   = "format";
  localparam logic [6*8-1:0]  KW_RM_RF    = "rm -rf";
  localparam logic [10*8-1:0] KW_DROP_TBL = "drop table";
  localparam logic [8*8-1:0]  KW_SHUTDOWN = "shutdown";
  localparam logic [4*8-1:0]  KW_HALT     = "halt";

  // configuration register indexes
  localparam logic [2:0] CFG_BASE_SELF_HEAL  = 3'd0;
  localparam logic [2:0] CFG_BASE_NOTIFY     = 3'd1;
  localparam logic [2:0] CFG_BASE_PROBE_HIGH = 3'd2;
  localparam logic [2:0] CFG_BASE_CONSULT    = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD       = 3'd4;

  // action classes
  localparam logic [2:0] CLS_SELF_HEAL  = 3'd0;
  localparam logic [2:0] CLS_NOTIFY     = 3'd1;
  localparam logic [2:0] CLS_PROBE_HIGH = 3'd2;
  localparam logic [2:0] CLS_CONSULT    = 3'd3;

  // trust levels
  localparam logic [2:0] TL_AUTO    = 3'd0;
  localparam logic [2:0] TL_NOTIFY  = 3'd1;
  localparam logic [2:0] TL_REQUEST = 3'd2;

  typedef enum logic [2:0] {
    DEC_REFUSE  = 3'd0,
    DEC_EXECUTE = 3'd1,
    DEC_NOTIFY  = 3'd2,
    DEC_REQUEST = 3'd3,
    DEC_PROPOSE = 3'd4
  } decision_t;

  typedef struct packed {
    logic [RISK_W-1:0] base_self_heal;
    logic [RISK_W-1:0] base_notify;
    logic [RISK_W-1:0] base_probe_high;
    logic [RISK_W-1:0] base_consult;
    logic [RISK_W-1:0] threshold;
  } cfg_t;

  // input word, last member in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic              approval_channel_up;
    logic [2:0]        trust_level;
    logic [RISK_W-1:0] learned_raise_x100;
    logic [2:0]        act_kind;
    logic [7:0]        trigger_byte;
  } in_word_t;

  typedef struct packed {
    logic             pad;
    decision_t        decision;
    logic             verdict;
    logic [SUM_W-1:0] risk_sum;
  } out_word_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    fold_case = (b >= "A" && b <= "Z") ? b + CASE_OFFSET : b;
  endfunction

  // window: newest byte in [7:0], older bytes above
  function automatic logic kw_match(input logic [KEYWORD_SPAN*8-1:0] win);
    kw_match = (win[6*8-1:0]  == KW_DELETE)   ||
               (win[6*8-1:0]  == KW_REMOVE)   ||
               (win[4*8-1:0]  == KW_KILL)     ||
               (win[7*8-1:0]  == KW_DESTROY)  ||
               (win[6*8-1:0]  == KW_FORMAT)   ||
               (win[6*8-1:0]  == KW_RM_RF)    ||
               (win[10*8-1:0] == KW_DROP_TBL) ||
               (win[8*8-1:0]  == KW_SHUTDOWN) ||
               (win[4*8-1:0]  == KW_HALT);
  endfunction

endpackage
`default_nettype wire

// File: src/kra_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_cfg
// Configuration registers: class base risks and block threshold.
// ----------------------------------------------------------------------------
module kra_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_addr,
  input  wire logic [kra_pkg::RISK_W-1:0] cfg_wdata,
  output kra_pkg::cfg_t                   cfg
);
  import kra_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_self_heal  <= '0;
      cfg_r.base_notify     <= '0;
      cfg_r.base_probe_high <= '0;
      cfg_r.base_consult    <= '0;
      cfg_r.threshold       <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BASE_SELF_HEAL:  cfg_r.base_self_heal  <= cfg_wdata;
        CFG_BASE_NOTIFY:     cfg_r.base_notify     <= cfg_wdata;
        CFG_BASE_PROBE_HIGH: cfg_r.base_probe_high <= cfg_wdata;
        CFG_BASE_CONSULT:    cfg_r.base_consult    <= cfg_wdata;
        CFG_THRESHOLD:       cfg_r.threshold       <= cfg_wdata;
        default: ;           // unused indexes ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: src/kra_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_scan
// Byte history and sticky keyword hit; flags a hit including the current byte.
// ----------------------------------------------------------------------------
module kra_scan (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,      // item leaves the input register
  input  wire logic [7:0] data_byte,
  input  wire logic       present,
  input  wire logic       last,
  output logic            hit_any
);
  import kra_pkg::*;

  logic [HIST_BYTES*8-1:0]   hist_r, hist_nxt;
  logic                      hit_r, hit_nxt;
  logic [KEYWORD_SPAN*8-1:0] win;
  logic                      hit_now;

  assign win     = {hist_r, fold_case(data_byte)};
  assign hit_now = present && kw_match(win);
  assign hit_any = hit_r || hit_now;

  always_comb begin
    hist_nxt = hist_r;
    hit_nxt  = hit_r;
    if (step) begin
      if (last) begin
        hist_nxt = '0;
        hit_nxt  = 1'b0;
      end else begin
        if (present) hist_nxt = win[HIST_BYTES*8-1:0];
        hit_nxt = hit_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      hist_r <= hist_nxt;
      hit_r  <= hit_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/kra_score.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_score
// Risk sum, block verdict and trust policy decision.
// ----------------------------------------------------------------------------
module kra_score (
  input  kra_pkg::cfg_t                   cfg,
  input  wire logic [2:0]                 act_kind,
  input  wire logic [kra_pkg::RISK_W-1:0] learned_raise_x100,
  input  wire logic [2:0]                 trust_level,
  input  wire logic                       approval_channel_up,
  input  wire logic                       hit,
  output logic [kra_pkg::SUM_W-1:0]       risk_sum,
  output logic                            verdict,
  output kra_pkg::decision_t              decision
);
  import kra_pkg::*;

  logic [RISK_W-1:0] base;

  always_comb begin
    case (act_kind)
      CLS_SELF_HEAL:  base = cfg.base_self_heal;
      CLS_NOTIFY:     base = cfg.base_notify;
      CLS_PROBE_HIGH: base = cfg.base_probe_high;
      CLS_CONSULT:    base = cfg.base_consult;
      default:        base = UNKNOWN_CLASS_RISK;
    endcase
  end

  assign risk_sum = {1'b0, base} + {1'b0, learned_raise_x100};
  assign verdict  = hit || (risk_sum >= {1'b0, cfg.threshold});

  always_comb begin
    if (verdict) begin
      decision = DEC_REFUSE;
    end else begin
      case (trust_level)
        TL_AUTO:    decision = DEC_EXECUTE;
        TL_NOTIFY:  decision = DEC_NOTIFY;
        TL_REQUEST: decision = approval_channel_up ? DEC_REQUEST : DEC_PROPOSE;
        default:    decision = DEC_REFUSE;   // require or unknown
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/keyword_risk_action_gate.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: input register stage, then result register stage, then out_*.
// Throughput: one word per cycle, sustained, while out_tready stays high.
// Backpressure only stalls on a last word whose result slot is still full.
// Reset (rst_n low, synchronous): both stages emptied, history and hit cleared,
// base risks to 0 and block threshold to 100.
// ----------------------------------------------------------------------------
// keyword_risk_action_gate
// Scans trigger-text bytes for risky keywords and scores the action on its
// last byte: risk, block verdict and trust-policy decision.
// ----------------------------------------------------------------------------
module keyword_risk_action_gate (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input stream
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [7:0] trigger_byte, [10:8] act_kind, [20:11] learned_raise_x100,
  // [23:21] trust_level, [24] approval_channel_up, [31:25] zero
  input  wire logic [31:0]                in_tdata,
  input  wire logic                       in_tuser,   // [0] trigger_present
  input  wire logic                       in_tlast,   // last_byte
  // result stream
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [10:0] risk_sum, [11] verdict, [14:12] decision, [15] zero
  output logic [15:0]                     out_tdata,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_addr,
  input  wire logic [kra_pkg::RISK_W-1:0] cfg_wdata
);
  import kra_pkg::*;

  // input register stage
  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      in_present_r;
  logic      in_last_r;

  // result register stage
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  logic      advance;
  logic      hit_any;
  cfg_t      cfg;
  out_word_t res;

  // A non-last word never produces a result, so it always moves on; a last
  // word needs the result slot free or draining this cycle.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_word_r    <= in_word_t'(in_tdata);
      in_present_r <= in_tuser;
      in_last_r    <= in_tlast;
    end
  end

  kra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kra_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_word_r.trigger_byte),
    .present   (in_present_r),
    .last      (in_last_r),
    .hit_any   (hit_any)
  );

  kra_score u_score (
    .cfg                 (cfg),
    .act_kind            (in_word_r.act_kind),
    .learned_raise_x100  (in_word_r.learned_raise_x100),
    .trust_level         (in_word_r.trust_level),
    .approval_channel_up (in_word_r.approval_channel_up),
    .hit                 (hit_any),
    .risk_sum            (res.risk_sum),
    .verdict             (res.verdict),
    .decision            (res.decision)
  );
  assign res.pad = 1'b0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_word_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_word_r);

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_risk_action_gate testbench
// Streams trigger text words into the gate and checks every result word
// against a scoreboard. A behavioral scorer inside this module rebuilds the
// byte history, keyword hit, risk sum, verdict and policy decision.
// Both stream sides idle at random outside the steady phase. Register settings
// change between traffic phases, while the gate is drained.
// ----------------------------------------------------------------------------
module testbench;
  import kra_pkg::*;

  // one input word, unpacked view
  typedef struct {
    logic [7:0]        ch;
    logic              present;
    logic              last;
    logic [2:0]        cls;
    logic [RISK_W-1:0] raise;
    logic [2:0]        trust;
    logic              chan;
  } trig_word_t;

  // one scored action
  typedef struct {
    logic [SUM_W-1:0] risk;
    logic             verdict;
    decision_t        decision;
  } score_t;

  typedef logic [7:0] text_t[$];

  localparam int                LIMIT_CYCLES  = 300000;
  localparam int                MAX_SHOWN     = 10;
  localparam int                DRAIN_CYCLES  = 8;
  localparam int                IDLE_PCT      = 31;
  localparam int                PHASES        = 6;
  localparam int                PHASE_WORDS   = 225;
  localparam logic [RISK_W-1:0] UNKNOWN_BASE  = 10'd100;
  localparam logic [2:0]        CLS_UNKNOWN   = 3'd7;
  localparam logic [2:0]        TL_REQUIRE    = 3'd3;
  localparam logic [2:0]        TL_UNKNOWN    = 3'd7;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              cfg_we     = 1'b0;
  logic [2:0]        cfg_addr   = '0;
  logic [RISK_W-1:0] cfg_wdata  = '0;

  keyword_risk_action_gate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words waiting for the driver, and scores waiting for the gate
  trig_word_t        pending_words[$];
  score_t            expected_scores[$];
  trig_word_t        cur_word;

  // scorer state: lowercased history (index 0 oldest), sticky hit, registers
  logic [7:0]        hist [HIST_BYTES] = '{default: 8'h00};
  logic              hit_seen = 1'b0;
  logic [RISK_W-1:0] class_base [4];
  logic [RISK_W-1:0] block_level;
  string             hazard_words [9];

  bit                steady;      // no idling on either side
  int                errors = 0;
  int                cycles = 0;

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  // Advance the scorer by one accepted word; a last word yields one score.
  function automatic void score_word(input trig_word_t w);
    logic [7:0]        win [KEYWORD_SPAN];
    logic [SUM_W-1:0]  risk;
    logic [RISK_W-1:0] base;
    logic              blocked;
    decision_t         dec;
    int                n;
    bit                same;
    // absent bytes skip the history and the scan entirely
    if (w.present) begin
      for (int i = 0; i < HIST_BYTES; i++) win[i] = hist[i];
      win[KEYWORD_SPAN-1] = lower(w.ch);
      foreach (hazard_words[k]) begin
        n = hazard_words[k].len();
        same = (n <= KEYWORD_SPAN);
        for (int i = 0; i < n && same; i++)
          if (win[KEYWORD_SPAN-n+i] != hazard_words[k][i]) same = 1'b0;
        if (same) hit_seen = 1'b1;
      end
      for (int i = 0; i < HIST_BYTES; i++) hist[i] = win[i+1];
    end
    if (w.last) begin
      if (w.cls <= CLS_CONSULT) base = class_base[w.cls[1:0]];
      else base = UNKNOWN_BASE;
      risk = base + w.raise;   // 11-bit sum, never wraps
      blocked = hit_seen || (risk >= block_level);
      if (blocked) begin
        dec = DEC_REFUSE;
      end else begin
        case (w.trust)
          TL_AUTO:    dec = DEC_EXECUTE;
          TL_NOTIFY:  dec = DEC_NOTIFY;
          TL_REQUEST: dec = w.chan ? DEC_REQUEST : DEC_PROPOSE;
          default:    dec = DEC_REFUSE;   // require and unknown levels
        endcase
      end
      expected_scores.push_back('{risk, blocked, dec});
      for (int i = 0; i < HIST_BYTES; i++) hist[i] = 8'h00;
      hit_seen = 1'b0;
    end
  endfunction

  function automatic trig_word_t noise_word(input logic present, input logic [7:0] ch);
    trig_word_t w;
    w.ch      = ch;
    w.present = present;
    w.last    = 1'b0;
    w.cls     = 3'($urandom_range(7));
    w.raise   = 10'($urandom_range(1023));
    w.trust   = 3'($urandom_range(7));
    w.chan    = 1'($urandom_range(1));
    return w;
  endfunction

  // Queue one action: its text bytes, absent words sprinkled in at gap_pct,
  // optionally an absent closing word. Scoring fields ride on the last word.
  function automatic void queue_action(input text_t txt, input int gap_pct,
                                       input bit tail_absent, input logic [2:0] cls,
                                       input logic [RISK_W-1:0] raise,
                                       input logic [2:0] trust, input logic chan);
    trig_word_t w;
    foreach (txt[i]) begin
      if ($urandom_range(99) < gap_pct)
        pending_words.push_back(noise_word(1'b0, 8'($urandom_range(255))));
      pending_words.push_back(noise_word(1'b1, txt[i]));
    end
    // empty trigger: a lone absent word closes the action
    if (tail_absent || txt.size() == 0)
      pending_words.push_back(noise_word(1'b0, 8'($urandom_range(255))));
    w = pending_words.pop_back();
    w.last  = 1'b1;
    w.cls   = cls;
    w.raise = raise;
    w.trust = trust;
    w.chan  = chan;
    pending_words.push_back(w);
  endfunction

  function automatic text_t text_of(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Random trigger text built from keywords in mixed case, near misses,
  // letters, separators and arbitrary bytes.
  function automatic text_t random_text();
    text_t      t;
    string      kw;
    int         pieces;
    int         skip;
    logic [7:0] c;
    pieces = $urandom_range(1, 4);
    for (int p = 0; p < pieces; p++) begin
      kw = hazard_words[$urandom_range(8)];
      case ($urandom_range(9))
        0, 1, 2: begin
          for (int i = 0; i < kw.len(); i++) begin
            c = kw[i];
            if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
            t.push_back(c);
          end
        end
        3: begin
          // keyword with one character dropped
          skip = $urandom_range(kw.len() - 1);
          for (int i = 0; i < kw.len(); i++)
            if (i != skip) t.push_back(kw[i]);
        end
        4, 5, 6: repeat ($urandom_range(1, 4)) t.push_back(8'(8'h61 + $urandom_range(25)));
        7:       t.push_back($urandom_range(1) ? " " : "-");
        8:       t.push_back(8'($urandom_range(255)));
        default: repeat ($urandom_range(1, 3)) t.push_back(8'(8'h41 + $urandom_range(25)));
      endcase
    end
    return t;
  endfunction

  // Register write; the scorer copy follows. Indexes above the threshold
  // register go nowhere.
  task automatic write_reg(input logic [2:0] idx, input logic [RISK_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_BASE_SELF_HEAL, CFG_BASE_NOTIFY, CFG_BASE_PROBE_HIGH, CFG_BASE_CONSULT:
        class_base[idx[1:0]] = val;
      CFG_THRESHOLD: block_level = val;
      default: ;
    endcase
  endtask

  // Sender holds off until every pending score has come back, then lets the
  // pipe settle (a non-last word leaves nothing to wait on).
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || expected_scores.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: hold a word until accepted, then maybe idle before the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) score_word(cur_word);
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cur_word = pending_words.pop_front();
          in_tdata  <= {7'd0, cur_word.chan, cur_word.trust, cur_word.raise,
                        cur_word.cls, cur_word.ch};
          in_tuser  <= cur_word.present;
          in_tlast  <= cur_word.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest score.
  always @(posedge clk) begin
    score_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_scores.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("[%0t] result word %h with no score pending", $realtime, out_tdata);
        end else begin
          want = expected_scores.pop_front();
          if (out_tdata[10:0] !== want.risk || out_tdata[11] !== want.verdict ||
              out_tdata[14:12] !== want.decision) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("[%0t] mismatch: risk %0d/%0d verdict %0d/%0d decision %0d/%0d (exp/act)",
                       $realtime, want.risk, out_tdata[10:0], want.verdict, out_tdata[11],
                       want.decision, out_tdata[14:12]);
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    text_t             t;
    logic [RISK_W-1:0] reg_val [8];
    logic [RISK_W-1:0] raise;
    logic [2:0]        trust;
    int                sent;
    int                n0;
    hazard_words = '{"delete", "remove", "kill", "destroy", "format", "rm -rf",
                     "drop table", "shutdown", "halt"};
    foreach (class_base[i]) class_base[i] = '0;
    block_level = 10'd100;
    steady      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values (bases 0, threshold 100).
    // empty trigger, unknown class: risk 100 meets the threshold
    t = {};
    queue_action(t, 0, 1'b0, CLS_UNKNOWN, 10'd0, TL_AUTO, 1'b0);
    // mixed case keyword with absent bytes inside and an absent last word
    queue_action(text_of("KiLL"), 50, 1'b1, CLS_SELF_HEAL, 10'd0, TL_AUTO, 1'b0);
    // longest keyword fills the whole window
    queue_action(text_of("Drop Table"), 0, 1'b0, CLS_CONSULT, 10'd99, TL_REQUEST, 1'b1);
    // 0x0D would fold to '-' if folding were not limited to letters
    t = text_of("rm -rf");
    t[3] = 8'h0D;
    queue_action(t, 0, 1'b0, CLS_SELF_HEAL, 10'd99, TL_REQUEST, 1'b0);
    // field extremes
    t = '{8'hFF};
    queue_action(t, 0, 1'b0, CLS_UNKNOWN, 10'd1023, TL_UNKNOWN, 1'b1);
    t = '{8'h00};
    queue_action(t, 0, 1'b0, CLS_NOTIFY, 10'd0, TL_NOTIFY, 1'b0);
    wait_drained();

    // Random phases: all-zero, all-ones, 1000 and random register settings.
    // Each phase ends drained, which is also where the sender is held off.
    for (int ph = 0; ph < PHASES; ph++) begin
      foreach (reg_val[r]) reg_val[r] = 10'($urandom_range(1023));
      for (int r = 0; r <= CFG_THRESHOLD; r++) begin
        case (ph)
          0:       reg_val[r] = '0;
          1:       reg_val[r] = '1;
          2:       reg_val[r] = 10'd1000;
          default: ;
        endcase
      end
      for (int r = 0; r < 8; r++) write_reg(3'(r), reg_val[r]);
      steady = (ph == 3);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        n0 = pending_words.size();
        raise = $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(150));
        trust = $urandom_range(3) ? 3'($urandom_range(TL_REQUIRE)) : 3'($urandom_range(7));
        if ($urandom_range(99) < 85) begin
          queue_action(random_text(), $urandom_range(1) ? 0 : 10, $urandom_range(9) == 0,
                       3'($urandom_range(7)), raise, trust, 1'($urandom_range(1)));
        end else begin
          // noise: arbitrary bytes, many absent words, sometimes empty
          t = {};
          repeat ($urandom_range(0, 6)) t.push_back(8'($urandom_range(255)));
          queue_action(t, 40, 1'($urandom_range(1)), 3'($urandom_range(7)), raise, trust,
                       1'($urandom_range(1)));
        end
        sent += pending_words.size() - n0;
      end
      wait_drained();
    end
    steady = 1'b0;

    if (errors == 0 && expected_scores.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
